// ----- hw/rtl/bia_pkg.sv -----
package bia_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 128;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SLOT_W    = 7;
    localparam int IDX_W     = 8;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    // Bitmap memory access, one port
    typedef struct packed
    {
        logic                 rd_en;
        logic                 wr_en;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } ram_req_t;

    typedef struct packed
    {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } result_t;

endpackage

// ----- hw/rtl/bia_bitmap_ram.sv -----
module bia_bitmap_ram
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ram_req_t             req,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] bitmap_reg [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 rd_valid_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            bitmap_reg[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= bitmap_reg[req.addr];
        end
    end

    // Per-word valid bits: an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/bia_engine.sv -----
module bia_engine
    import bia_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  op_t                  in_op,
    input  logic [IDX_W-1:0]     in_idx,
    output ram_req_t             ram_req,
    input  logic [WORD_BITS-1:0] rd_data,
    input  logic                 out_ready,
    output logic                 res_valid,
    output result_t              res
);

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    word_reg;
    result_t              res_reg;

    logic                 in_range;
    logic                 in_bad;
    logic [WORD_BITS-1:0] inv;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     pos;
    logic                 word_full;
    logic                 last_word;
    logic [WORD_BITS-1:0] free_mask;
    logic                 hit;

    // Request decode
    assign in_range = (32'(in_idx) < POOL_SIZE);
    assign in_bad   = (in_op == OP_FREE) && !in_range;

    // Lowest clear bit as a one-hot, then encoded
    assign inv       = ~rd_data;
    assign lowest    = inv & (~inv + WORD_BITS'(1));
    assign word_full = &rd_data;
    assign last_word = (word_reg == ADDR_W'(NUM_WORDS - 1));

    always_comb
    begin
        pos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (lowest[j])
            begin
                pos = pos | BIT_W'(j);
            end
        end
    end

    assign free_mask = WORD_BITS'(1) << idx_reg[BIT_W-1:0];
    assign hit       = |(rd_data & free_mask);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_bad ? S_EMIT : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!(op_reg == OP_ALLOC && word_full && !last_word))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and memory port
    always_comb
    begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_req.rd_en = 1'b0;
        ram_req.wr_en = 1'b0;
        ram_req.addr  = word_reg;
        ram_req.wdata = rd_data;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                ram_req.rd_en = in_valid && !in_bad;
                ram_req.addr  = (in_op == OP_ALLOC) ? '0 : in_idx[BIT_W +: ADDR_W];
            end
            S_CHECK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (!word_full)
                    begin
                        ram_req.wr_en = 1'b1;
                        ram_req.wdata = rd_data | lowest;
                    end
                    else if (!last_word)
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = word_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    ram_req.wr_en = hit;
                    ram_req.wdata = rd_data & ~free_mask;
                end
            end
            S_EMIT:
            begin
                res_valid = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request and result datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= in_op;
            idx_reg  <= in_idx;
            word_reg <= (in_op == OP_ALLOC) ? '0 : in_idx[BIT_W +: ADDR_W];
            res_reg  <= '{slot: '0, status: ST_RANGE};
        end
        else if (state_reg == S_CHECK)
        begin
            if (op_reg == OP_ALLOC)
            begin
                if (!word_full)
                begin
                    res_reg <= '{slot: SLOT_W'({word_reg, pos}), status: ST_OK};
                end
                else if (last_word)
                begin
                    res_reg <= '{slot: '0, status: ST_FULL};
                end
                else
                begin
                    word_reg <= word_reg + ADDR_W'(1);
                end
            end
            else
            begin
                res_reg <= '{slot: '0, status: (hit ? ST_OK : ST_NOT_USED)};
            end
        end
    end

endmodule

// ----- hw/rtl/bitmap_id_allocator.sv -----
// Channel  Dir  tdata                      tuser
// s_*      in   [7:0] free_index           [0] op (0 alloc, 1 free)
// m_*      out  [6:0] slot_index, [7] 0    [1:0] status
//
// A free passes issue, read-modify-write and emit between accept and result;
// an out-of-range free skips the read-modify-write.
// An allocate scans k words (k = 1..4) between issue and emit; one bitmap word is
// read per cycle from the single-port bitmap memory, which sets the scan time.
// One request at a time; a new word is taken once the previous result sits in
// the output register. Reset clears control state and the per-word valid bits,
// so the bitmap reads all free at once. m_tready low holds the result in place.
module bitmap_id_allocator
    import bia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] free_index
    input  logic [0:0] s_tuser,   // [0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] slot_index, [7] zero
    output logic [1:0] m_tuser    // [1:0] status
);

    ram_req_t             ram_req;
    logic [WORD_BITS-1:0] rd_data;
    logic                 out_ready;
    logic                 res_valid;
    result_t              res;

    logic                 m_tvalid_reg;
    logic [SLOT_W-1:0]    slot_reg;
    status_t              status_reg;

    assign out_ready = !m_tvalid_reg || m_tready;

    bia_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser[0])),
        .in_idx    (s_tdata),
        .ram_req   (ram_req),
        .rd_data   (rd_data),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    bia_bitmap_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            slot_reg   <= res.slot;
            status_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, slot_reg};
    assign m_tuser  = status_reg;

    // One request in flight: no new word right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while a request is in flight");

    // Memory port never reads and writes in the same cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("bitmap read and write collide");

    // Only a granted allocate carries a nonzero slot
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 8'd0))
        else $error("nonzero slot on a failed request");

    // A result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !res_valid)
        else $error("pending result overwritten");

endmodule
